// ===== rtl/core/tmpr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Tile map pixel renderer package
// Shared types, codes and sizing constants for the tile map renderer.
// ---------------------------------------------------------------------------
package tmpr_pkg;

    localparam int DEF_TILE_COUNT = 1024;
    localparam int DEF_MAP_ROWS   = 64;

    // Map row widths in tiles
    localparam int MAP_WIDTH_NARROW = 32;
    localparam int MAP_WIDTH_WIDE   = 64;

    // Command queue between the front and the back
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int CQ_PTR_W        = $clog2(CMD_QUEUE_DEPTH);
    localparam int CQ_CNT_W        = $clog2(CMD_QUEUE_DEPTH + 1);

    // Pixel queue at the result side
    localparam int OUT_QUEUE_DEPTH = 4;
    localparam int OQ_PTR_W        = $clog2(OUT_QUEUE_DEPTH);
    localparam int OQ_CNT_W        = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam int OQ_OCC_W        = OQ_CNT_W + 1;

    // Configuration register indexes
    localparam logic CFG_COLOR_MODE = 1'b0;
    localparam logic CFG_MAP_WIDE   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PAL_WR  = 2'd0,
        ACT_TILE_WR = 2'd1,
        ACT_DRAW    = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef struct packed {
        action_t     kind;
        logic [7:0]  palette_address;
        logic [14:0] color_word;
        logic [9:0]  tile_number;
        logic        tile_ok;
        logic [2:0]  pixel_column;
        logic [2:0]  pixel_row;
        logic [7:0]  pixel_value;
        logic [3:0]  palette_bank;
        logic        flip_horizontal;
        logic        flip_vertical;
    } cmd_t;

    typedef struct packed {
        logic [8:0]  screen_x;
        logic [8:0]  screen_y;
        logic [14:0] color;
        logic        final_pixel;
    } pixel_t;

    typedef struct packed {
        logic                drawing;
        logic [OQ_OCC_W-1:0] occupancy;
    } back_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tmpr_cmd_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Command front end
// Accepts input transactions, decodes the action into a command and holds
// it in a short queue until the render back end takes it.
// ---------------------------------------------------------------------------
module tmpr_cmd_queue
    import tmpr_pkg::*;
#(
    parameter int TILE_COUNT = DEF_TILE_COUNT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_palette_address,
    input  wire logic [14:0] s_color_word,
    input  wire logic [9:0]  s_tile_number,
    input  wire logic [2:0]  s_pixel_column,
    input  wire logic [2:0]  s_pixel_row,
    input  wire logic [7:0]  s_pixel_value,
    input  wire logic [3:0]  s_palette_bank,
    input  wire logic        s_flip_horizontal,
    input  wire logic        s_flip_vertical,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);

    cmd_t                queue_reg [CMD_QUEUE_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    cmd_t                entry;
    logic                push;
    logic                pop;

    always_comb begin
        entry.kind            = action_t'(s_action);
        entry.palette_address = s_palette_address;
        entry.color_word      = s_color_word;
        entry.tile_number     = s_tile_number;
        // Tiles past the end of the store are ignored on write and read as zero.
        entry.tile_ok         = (int'(s_tile_number) < TILE_COUNT);
        entry.pixel_column    = s_pixel_column;
        entry.pixel_row       = s_pixel_row;
        entry.pixel_value     = s_pixel_value;
        entry.palette_bank    = s_palette_bank;
        entry.flip_horizontal = s_flip_horizontal;
        entry.flip_vertical   = s_flip_vertical;
    end

    assign s_ready   = (count_reg != CQ_CNT_W'(CMD_QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + CQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CQ_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tmpr_render.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Render back end
// Executes commands: palette and tile writes, position restart, and draws
// that stream 64 pixels through tile read, palette read and a pixel queue.
// ---------------------------------------------------------------------------
module tmpr_render
    import tmpr_pkg::*;
#(
    parameter int TILE_COUNT = DEF_TILE_COUNT,
    parameter int MAP_ROWS   = DEF_MAP_ROWS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic       cfg_wr_data,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire cmd_t       cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [8:0]      m_screen_x,
    output logic [8:0]      m_screen_y,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue,
    output logic            m_final_pixel,
    output back_status_t    status
);

    localparam int TILE_DEPTH = TILE_COUNT * 64;
    localparam int TILE_AW    = $clog2(TILE_DEPTH);

    typedef enum logic {ST_IDLE, ST_DRAW} state_t;

    state_t      state_reg, state_next;
    logic        color_mode_reg, map_wide_reg;
    logic [5:0]  map_col_reg, map_col_next;
    logic [5:0]  map_row_reg, map_row_next;
    logic [5:0]  pix_cnt_reg, pix_cnt_next;
    logic [9:0]  tile_reg;
    logic        tile_ok_reg;
    logic [3:0]  bank_reg;
    logic        hflip_reg, vflip_reg;

    // Stores
    logic [14:0] pal_mem  [256];
    logic [7:0]  tile_mem [TILE_DEPTH];
    logic [14:0] pal_rdata_reg;
    logic [7:0]  tile_rdata_reg;
    logic [TILE_AW-1:0] tile_waddr, tile_raddr;
    logic [7:0]  pal_raddr;
    logic [7:0]  pix_index;
    logic        tile_we, pal_we;

    // Pixel pipeline
    logic        s1_valid_reg, s2_valid_reg;
    logic [8:0]  s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg;
    logic        s1_last_reg, s2_last_reg;
    logic [3:0]  s1_bank_reg;
    logic        s1_ok_reg;

    // Pixel queue
    pixel_t              oq_reg [OUT_QUEUE_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;
    logic [OQ_OCC_W-1:0] occupancy;
    pixel_t              oq_head;
    pixel_t              oq_entry;
    logic                oq_push, oq_pop;

    logic        cmd_take;
    logic        issue;
    logic        last_issue;
    logic [2:0]  col_idx, row_idx;
    logic [2:0]  disp_col, disp_row;
    logic [5:0]  col_inc, row_inc;
    logic        col_wrap, row_wrap;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd_valid && cmd_ready;

    // A pixel is issued only when the queue has room for everything in flight.
    assign occupancy = OQ_OCC_W'(oq_count_reg) + OQ_OCC_W'(s1_valid_reg)
                     + OQ_OCC_W'(s2_valid_reg);
    assign issue      = (state_reg == ST_DRAW) && (occupancy < OQ_OCC_W'(OUT_QUEUE_DEPTH));
    assign last_issue = issue && (pix_cnt_reg == 6'd63);

    assign col_idx  = pix_cnt_reg[2:0];
    assign row_idx  = pix_cnt_reg[5:3];
    assign disp_col = hflip_reg ? ~col_idx : col_idx;
    assign disp_row = vflip_reg ? ~row_idx : row_idx;

    assign col_inc  = map_col_reg + 6'd1;
    assign row_inc  = map_row_reg + 6'd1;
    assign col_wrap = (col_inc == 6'd0)
                   || ({1'b0, col_inc} >= (map_wide_reg ? 7'(MAP_WIDTH_WIDE)
                                                        : 7'(MAP_WIDTH_NARROW)));
    assign row_wrap = (row_inc == 6'd0) || ({1'b0, row_inc} >= 7'(MAP_ROWS));

    always_comb begin
        state_next   = state_reg;
        pix_cnt_next = pix_cnt_reg;
        map_col_next = map_col_reg;
        map_row_next = map_row_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_take) begin
                    case (cmd.kind)
                        ACT_DRAW: begin
                            state_next   = ST_DRAW;
                            pix_cnt_next = '0;
                        end
                        ACT_RESTART: begin
                            map_col_next = '0;
                            map_row_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                if (issue) begin
                    pix_cnt_next = pix_cnt_reg + 6'd1;
                end
                if (last_issue) begin
                    state_next = ST_IDLE;
                    if (col_wrap) begin
                        map_col_next = '0;
                        map_row_next = row_wrap ? 6'd0 : row_inc;
                    end else begin
                        map_col_next = col_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pix_cnt_reg    <= '0;
            map_col_reg    <= '0;
            map_row_reg    <= '0;
            color_mode_reg <= 1'b0;
            map_wide_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pix_cnt_reg <= pix_cnt_next;
            map_col_reg <= map_col_next;
            map_row_reg <= map_row_next;
            if (cfg_wr_en && cfg_index == CFG_COLOR_MODE) begin
                color_mode_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == CFG_MAP_WIDE) begin
                map_wide_reg <= cfg_wr_data;
            end
        end
    end

    // Draw parameters
    always_ff @(posedge aclk) begin
        if (cmd_take && cmd.kind == ACT_DRAW) begin
            tile_reg    <= cmd.tile_number;
            tile_ok_reg <= cmd.tile_ok;
            bank_reg    <= cmd.palette_bank;
            hflip_reg   <= cmd.flip_horizontal;
            vflip_reg   <= cmd.flip_vertical;
        end
    end

    // Tile store: pixel at tile * 64 + column * 8 + row.
    assign tile_we    = cmd_take && (cmd.kind == ACT_TILE_WR) && cmd.tile_ok;
    assign tile_waddr = TILE_AW'({cmd.tile_number, cmd.pixel_column, cmd.pixel_row});
    assign tile_raddr = TILE_AW'({tile_reg, col_idx, row_idx});

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[tile_waddr] <= cmd.pixel_value;
        end
        tile_rdata_reg <= tile_mem[tile_raddr];
    end

    // Palette store
    assign pal_we    = cmd_take && (cmd.kind == ACT_PAL_WR);
    assign pix_index = s1_ok_reg ? tile_rdata_reg : 8'd0;
    assign pal_raddr = color_mode_reg ? pix_index : ({s1_bank_reg, 4'd0} + pix_index);

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[cmd.palette_address] <= cmd.color_word;
        end
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_x_reg    <= {map_col_reg, disp_col};
        s1_y_reg    <= {map_row_reg, disp_row};
        s1_last_reg <= (pix_cnt_reg == 6'd63);
        s1_bank_reg <= bank_reg;
        s1_ok_reg   <= tile_ok_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_last_reg <= s1_last_reg;
    end

    // Pixel queue
    assign oq_push = s2_valid_reg;
    assign oq_pop  = m_valid && m_ready;

    always_comb begin
        oq_entry.screen_x    = s2_x_reg;
        oq_entry.screen_y    = s2_y_reg;
        oq_entry.color       = pal_rdata_reg;
        oq_entry.final_pixel = s2_last_reg;
        oq_count_next        = oq_count_reg;
        if (oq_push && !oq_pop) begin
            oq_count_next = oq_count_reg + OQ_CNT_W'(1);
        end else if (oq_pop && !oq_push) begin
            oq_count_next = oq_count_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end else begin
            oq_count_reg <= oq_count_next;
            if (oq_push) begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (oq_push) begin
            oq_reg[oq_wr_ptr_reg] <= oq_entry;
        end
    end

    assign oq_head       = oq_reg[oq_rd_ptr_reg];
    assign m_valid       = (oq_count_reg != '0);
    assign m_screen_x    = oq_head.screen_x;
    assign m_screen_y    = oq_head.screen_y;
    assign m_red         = {oq_head.color[4:0], 3'd0};
    assign m_green       = {oq_head.color[9:5], 3'd0};
    assign m_blue        = {oq_head.color[14:10], 3'd0};
    assign m_final_pixel = oq_head.final_pixel;

    assign status.drawing   = (state_reg == ST_DRAW);
    assign status.occupancy = occupancy;

endmodule
`default_nettype wire

// ===== rtl/core/tile_map_pixel_renderer_top.sv =====
`default_nettype none
// A draw's 64 pixels pass the tile and palette read registers into the pixel
// queue, issued at one per cycle while the queue has room, a rate set by the
// single tile store read port; writes and restarts act as the command is
// taken. Reset clears the queues, map position and configuration; palette
// and tile stores are undefined until written.
// ---------------------------------------------------------------------------
// Tile map pixel renderer
// Renders 8x8 tiles through a 256-entry palette into positioned pixels.
// ---------------------------------------------------------------------------
module tile_map_pixel_renderer_top
    import tmpr_pkg::*;
#(
    parameter int TILE_COUNT = DEF_TILE_COUNT,
    parameter int MAP_ROWS   = DEF_MAP_ROWS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_palette_address,
    input  wire logic [14:0] s_color_word,
    input  wire logic [9:0]  s_tile_number,
    input  wire logic [2:0]  s_pixel_column,
    input  wire logic [2:0]  s_pixel_row,
    input  wire logic [7:0]  s_pixel_value,
    input  wire logic [3:0]  s_palette_bank,
    input  wire logic        s_flip_horizontal,
    input  wire logic        s_flip_vertical,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [8:0]       m_screen_x,
    output logic [8:0]       m_screen_y,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic             m_final_pixel
);

    logic         cmd_valid;
    logic         cmd_ready;
    cmd_t         cmd;
    back_status_t back_status;

    tmpr_cmd_queue #(
        .TILE_COUNT(TILE_COUNT)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_palette_address(s_palette_address),
        .s_color_word     (s_color_word),
        .s_tile_number    (s_tile_number),
        .s_pixel_column   (s_pixel_column),
        .s_pixel_row      (s_pixel_row),
        .s_pixel_value    (s_pixel_value),
        .s_palette_bank   (s_palette_bank),
        .s_flip_horizontal(s_flip_horizontal),
        .s_flip_vertical  (s_flip_vertical),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd)
    );

    tmpr_render #(
        .TILE_COUNT(TILE_COUNT),
        .MAP_ROWS  (MAP_ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_screen_x   (m_screen_x),
        .m_screen_y   (m_screen_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_final_pixel(m_final_pixel),
        .status       (back_status)
    );

    // A full command queue always has a command waiting for the back end.
    a_full_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> cmd_valid)
        else $error("input stalled with no command queued");

    // A draw taken by the back end starts a pixel run on the next cycle.
    a_draw_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready && cmd.kind == ACT_DRAW) |=> back_status.drawing)
        else $error("draw command did not start a pixel run");

    // No command is taken while a draw is still issuing pixels.
    a_no_take_while_drawing: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.drawing |-> !cmd_ready)
        else $error("command taken during a draw");

    // Pixels in flight never exceed the room in the pixel queue.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.occupancy <= OQ_OCC_W'(OUT_QUEUE_DEPTH))
        else $error("pixel queue overrun");

endmodule
`default_nettype wire

// ===== verif/tb_tile_map_pixel_renderer_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tile map pixel renderer testbench
// Loads palette entries and tile pixels, draws map entries and checks every
// pixel against a behavioral model held in the bench, under several idle and
// stall patterns, both color modes and both map widths.
// ---------------------------------------------------------------------------
module tb_tile_map_pixel_renderer_top;
    import tmpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 10;
    localparam int POOL_SIZE      = 8;

    typedef struct {
        action_t     kind;
        logic [7:0]  palette_address;
        logic [14:0] color_word;
        logic [9:0]  tile_number;
        logic [2:0]  pixel_column;
        logic [2:0]  pixel_row;
        logic [7:0]  pixel_value;
        logic [3:0]  palette_bank;
        logic        flip_horizontal;
        logic        flip_vertical;
    } render_item_t;

    typedef struct {
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       final_pixel;
    } pixel_expect_t;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        cfg_wr_en         = 1'b0;
    logic        cfg_index         = 1'b0;
    logic        cfg_wr_data       = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action          = '0;
    logic [7:0]  s_palette_address = '0;
    logic [14:0] s_color_word      = '0;
    logic [9:0]  s_tile_number     = '0;
    logic [2:0]  s_pixel_column    = '0;
    logic [2:0]  s_pixel_row       = '0;
    logic [7:0]  s_pixel_value     = '0;
    logic [3:0]  s_palette_bank    = '0;
    logic        s_flip_horizontal = 1'b0;
    logic        s_flip_vertical   = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [8:0]  m_screen_x;
    logic [8:0]  m_screen_y;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_final_pixel;

    // Bench copy of the renderer state.
    logic [14:0] pal_mem [256];
    logic        pal_written [256];
    logic [7:0]  tile_mem [DEF_TILE_COUNT][64];
    logic [63:0] tile_written [DEF_TILE_COUNT];
    logic [5:0]  map_col = '0;
    logic [5:0]  map_row = '0;
    logic        color_mode_sh = 1'b0;
    logic        map_wide_sh = 1'b0;

    pixel_expect_t pending_pixels[$];
    logic [9:0]    tile_pool [POOL_SIZE];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req_cnt   = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    tile_map_pixel_renderer_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_palette_address (s_palette_address),
        .s_color_word      (s_color_word),
        .s_tile_number     (s_tile_number),
        .s_pixel_column    (s_pixel_column),
        .s_pixel_row       (s_pixel_row),
        .s_pixel_value     (s_pixel_value),
        .s_palette_bank    (s_palette_bank),
        .s_flip_horizontal (s_flip_horizontal),
        .s_flip_vertical   (s_flip_vertical),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_screen_x        (m_screen_x),
        .m_screen_y        (m_screen_y),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue),
        .m_final_pixel     (m_final_pixel)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Applies one accepted transaction to the bench state and queues the
    // pixels a draw produces.
    function automatic void predict_pixels(input render_item_t it);
        pixel_expect_t px;
        logic [7:0]    idx;
        logic [7:0]    addr;
        logic [14:0]   c;
        logic [2:0]    cc;
        logic [2:0]    rr;
        logic [2:0]    dx;
        logic [2:0]    dy;
        int            width;
        case (it.kind)
            ACT_PAL_WR: begin
                pal_mem[it.palette_address]     = it.color_word;
                pal_written[it.palette_address] = 1'b1;
            end
            ACT_TILE_WR: begin
                if (it.tile_number < DEF_TILE_COUNT) begin
                    tile_mem[it.tile_number][{it.pixel_column, it.pixel_row}] = it.pixel_value;
                    tile_written[it.tile_number][{it.pixel_column, it.pixel_row}] = 1'b1;
                end
            end
            ACT_RESTART: begin
                map_col = '0;
                map_row = '0;
            end
            default: begin
                for (int r = 0; r < 8; r++) begin
                    for (int k = 0; k < 8; k++) begin
                        cc  = 3'(k);
                        rr  = 3'(r);
                        idx = (it.tile_number < DEF_TILE_COUNT) ?
                              tile_mem[it.tile_number][{cc, rr}] : 8'd0;
                        addr = color_mode_sh ? idx : {it.palette_bank, 4'b0000} + idx;
                        c  = pal_mem[addr];
                        dx = it.flip_horizontal ? 3'd7 - cc : cc;
                        dy = it.flip_vertical ? 3'd7 - rr : rr;
                        px.x = {map_col, dx};
                        px.y = {map_row, dy};
                        px.r = {c[4:0], 3'b000};
                        px.g = {c[9:5], 3'b000};
                        px.b = {c[14:10], 3'b000};
                        px.final_pixel = (r == 7) && (k == 7);
                        pending_pixels.push_back(px);
                    end
                end
                // A column beyond a narrowed row width also wraps to the next row.
                width   = map_wide_sh ? MAP_WIDTH_WIDE : MAP_WIDTH_NARROW;
                map_col = map_col + 6'd1;
                if (int'(map_col) >= width || map_col == 6'd0) begin
                    map_col = '0;
                    map_row = map_row + 6'd1;
                    if (int'(map_row) >= DEF_MAP_ROWS)
                        map_row = '0;
                end
            end
        endcase
    endfunction

    function automatic render_item_t random_item(input action_t kind);
        render_item_t it;
        it.kind            = kind;
        it.palette_address = 8'($urandom_range(255));
        it.color_word      = 15'($urandom_range(32767));
        it.tile_number     = 10'($urandom_range(1023));
        it.pixel_column    = 3'($urandom_range(7));
        it.pixel_row       = 3'($urandom_range(7));
        it.pixel_value     = 8'($urandom_range(255));
        it.palette_bank    = 4'($urandom_range(15));
        it.flip_horizontal = 1'($urandom_range(1));
        it.flip_vertical   = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Valid stays high after an accepted transaction; whoever waits next lowers it.
    task automatic send_item(input render_item_t it);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= it.kind;
        s_palette_address <= it.palette_address;
        s_color_word      <= it.color_word;
        s_tile_number     <= it.tile_number;
        s_pixel_column    <= it.pixel_column;
        s_pixel_row       <= it.pixel_row;
        s_pixel_value     <= it.pixel_value;
        s_palette_bank    <= it.palette_bank;
        s_flip_horizontal <= it.flip_horizontal;
        s_flip_vertical   <= it.flip_vertical;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_pixels(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic mode, input logic wide);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_COLOR_MODE;
        cfg_wr_data <= mode;
        @(posedge aclk);
        color_mode_sh = mode;
        cfg_index   <= CFG_MAP_WIDE;
        cfg_wr_data <= wide;
        @(posedge aclk);
        map_wide_sh = wide;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_palette(input logic [7:0] addr, input logic [14:0] color);
        render_item_t it;
        it = random_item(ACT_PAL_WR);
        it.palette_address = addr;
        it.color_word      = color;
        send_item(it);
    endtask

    task automatic write_tile_pixel(input logic [9:0] tile, input logic [2:0] col,
                                    input logic [2:0] row, input logic [7:0] value);
        render_item_t it;
        it = random_item(ACT_TILE_WR);
        it.tile_number  = tile;
        it.pixel_column = col;
        it.pixel_row    = row;
        it.pixel_value  = value;
        send_item(it);
    endtask

    task automatic restart_position();
        send_item(random_item(ACT_RESTART));
    endtask

    // Loads any tile pixel and palette entry the draw would read that was
    // never written, then sends the draw itself.
    task automatic draw_entry(input logic [9:0] tile, input logic [3:0] bank,
                              input logic hflip, input logic vflip);
        render_item_t it;
        logic [7:0]   addr;
        for (int p = 0; p < 64; p++) begin
            if (!tile_written[tile][p])
                write_tile_pixel(tile, 3'(p >> 3), 3'(p), 8'($urandom_range(255)));
        end
        for (int p = 0; p < 64; p++) begin
            addr = color_mode_sh ? tile_mem[tile][p] : {bank, 4'b0000} + tile_mem[tile][p];
            if (!pal_written[addr])
                write_palette(addr, 15'($urandom_range(32767)));
        end
        it = random_item(ACT_DRAW);
        it.tile_number     = tile;
        it.palette_bank    = bank;
        it.flip_horizontal = hflip;
        it.flip_vertical   = vflip;
        send_item(it);
    endtask

    task automatic draw_from_pool();
        draw_entry(tile_pool[$urandom_range(POOL_SIZE - 1)], 4'($urandom_range(15)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(1'b0, 1'b0);
        write_palette(8'd0, 15'h0000);
        write_palette(8'd255, 15'h7FFF);
        write_palette(8'd240, 15'h001F);
        write_palette(8'd15, 15'h03E0);
        write_palette(8'd1, 15'h7C00);
        write_tile_pixel(10'd0, 3'd0, 3'd0, 8'h00);
        write_tile_pixel(10'd0, 3'd7, 3'd7, 8'hFF);
        write_tile_pixel(10'd0, 3'd7, 3'd0, 8'h0F);
        write_tile_pixel(10'd0, 3'd0, 3'd7, 8'h01);
        draw_entry(10'd0, 4'd0, 1'b0, 1'b0);
        draw_entry(10'd0, 4'd15, 1'b1, 1'b0);
        draw_entry(10'd0, 4'd15, 1'b0, 1'b1);
        draw_entry(10'd0, 4'd0, 1'b1, 1'b1);
        write_tile_pixel(10'd1023, 3'd3, 3'd5, 8'hF0);
        draw_entry(10'd1023, 4'd15, 1'b1, 1'b1);
        // Restart must bring the next entry back to the screen origin.
        restart_position();
        draw_entry(10'd0, 4'd8, 1'b0, 1'b0);
        set_config(1'b1, 1'b0);
        draw_entry(10'd0, 4'd0, 1'b0, 1'b0);
        draw_entry(10'd1023, 4'd5, 1'b1, 1'b0);
        restart_position();
    endtask

    // Runs past column 63 in wide mode, stops at a column beyond 32 and
    // narrows the map so the next advance has to wrap.
    task automatic test_map_width_change();
        src_idle_pct   = 18;
        sink_stall_pct = 18;
        set_config(1'b0, 1'b1);
        restart_position();
        repeat (MAP_WIDTH_WIDE + 40) draw_from_pool();
        set_config(1'b0, 1'b0);
        repeat (3) draw_from_pool();
    endtask

    // Walks the whole narrow map so the row counter wraps past the last row.
    task automatic test_row_wrap();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(1'b0, 1'b0);
        restart_position();
        repeat (MAP_WIDTH_NARROW * DEF_MAP_ROWS + 3) draw_from_pool();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(1'b1, 1'b0);
        hold_req_cnt++;
        repeat (8) draw_from_pool();
        // Sender waits here until every queued pixel has come out.
        wait_drained();
        repeat (3) draw_from_pool();
    endtask

    task automatic test_random(input logic mode, input logic wide, input int src_pct,
                               input int sink_pct, input int count);
        int pick;
        set_config(mode, wide);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45)
                draw_from_pool();
            else if (pick < 62)
                write_palette(8'($urandom_range(255)), 15'($urandom_range(32767)));
            else if (pick < 80)
                write_tile_pixel(tile_pool[$urandom_range(POOL_SIZE - 1)],
                                 3'($urandom_range(7)), 3'($urandom_range(7)),
                                 8'($urandom_range(255)));
            else if (pick < 89)
                write_tile_pixel(10'($urandom_range(1023)), 3'($urandom_range(7)),
                                 3'($urandom_range(7)), 8'($urandom_range(255)));
            else if (pick < 95)
                restart_position();
            else
                draw_entry(10'($urandom_range(1023)), 4'($urandom_range(15)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_taken != hold_req_cnt) begin
            hold_taken = hold_req_cnt;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        pixel_expect_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel at (%0d, %0d) arrived with no expected pixel pending",
                       m_screen_x, m_screen_y);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("screen_x", 16'(want.x), 16'(m_screen_x));
                check_field("screen_y", 16'(want.y), 16'(m_screen_y));
                check_field("red", 16'(want.r), 16'(m_red));
                check_field("green", 16'(want.g), 16'(m_green));
                check_field("blue", 16'(want.b), 16'(m_blue));
                check_field("final_pixel", 16'(want.final_pixel), 16'(m_final_pixel));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 256; i++)
            pal_written[i] = 1'b0;
        for (int i = 0; i < DEF_TILE_COUNT; i++)
            tile_written[i] = '0;
        tile_pool[0] = 10'd0;
        tile_pool[1] = 10'd1023;
        for (int i = 2; i < POOL_SIZE; i++)
            tile_pool[i] = 10'($urandom_range(1023));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_map_width_change();
        test_row_wrap();
        test_backpressure();
        test_random(1'b0, 1'b0, 0, 0, 70);
        test_random(1'b1, 1'b0, 54, 0, 70);
        test_random(1'b0, 1'b1, 0, 54, 70);
        test_random(1'b1, 1'b1, 18, 18, 70);

        wait_drained();
        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
